>>> rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types and codes of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

	typedef enum logic [1:0] {
		ST_TWO    = 2'd0,
		ST_LINEAR = 2'd1,
		ST_NONE   = 2'd2,
		ST_DEGEN  = 2'd3
	} status_t;

endpackage

>>> rtl/qrs_disc.sv
// ----------------------------------------------------------------------------
// qrs_disc
// two stage front end: products, then discriminant and case decision
// ----------------------------------------------------------------------------
module qrs_disc #(
	parameter int W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	input  logic signed [W-1:0]   c,
	output logic                  out_valid,
	output logic [2*W+1:0]        d,
	output logic [3*W+1:0]        pl_out
);
	import qrs_pkg::*;

	logic                  v_s1;
	logic signed [W-1:0]   a_s1, b_s1, c_s1;
	logic signed [2*W-1:0] bb_s1, ac_s1;
	logic                  v_s2;
	logic [2*W+1:0]        d_s2;
	logic [3*W+1:0]        pl_s2;

	logic signed [2*W+2:0] bbx, acx, dd;
	status_t               st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= a;
			b_s1  <= b;
			c_s1  <= c;
			bb_s1 <= b * b;
			ac_s1 <= a * c;
			d_s2  <= (st == ST_TWO) ? dd[2*W+1:0] : '0;
			pl_s2 <= {a_s1, b_s1, c_s1, st};
		end
	end

	assign bbx = (2*W+3)'(bb_s1);
	assign acx = (2*W+3)'(ac_s1);
	assign dd  = bbx - (acx <<< 2);

	always_comb begin
		priority if (a_s1 == '0) begin
			st = (b_s1 == '0) ? ST_DEGEN : ST_LINEAR;
		end else if (dd < 0) begin
			st = ST_NONE;
		end else begin
			st = ST_TWO;
		end
	end

	assign out_valid = v_s2;
	assign d         = d_s2;
	assign pl_out    = pl_s2;

endmodule

>>> rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined digit-by-digit square root of d * 2^(2*FB), one bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt #(
	parameter int DW = 34,
	parameter int SQ = 34,
	parameter int FB = 16,
	parameter int PW = 50
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] d,
	input  logic [PW-1:0] pl_in,
	output logic          out_valid,
	output logic [SQ-1:0] root,
	output logic [PW-1:0] pl_out
);
	localparam int RW = SQ + 2;
	localparam int XW = 2 * SQ;

	logic          v_s    [SQ+1];
	logic [RW-1:0] rem_s  [SQ+1];
	logic [SQ-1:0] root_s [SQ+1];
	logic [XW-1:0] x_s    [SQ+1];
	logic [PW-1:0] pl_s   [SQ+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = XW'(d) << (2 * FB);
	assign pl_s[0]   = pl_in;

	for (genvar k = 0; k < SQ; k++) begin : g_stage
		logic [RW-1:0] rem_n, trial;
		logic          ge;

		assign rem_n = {rem_s[k][RW-3:0], x_s[k][XW-1:XW-2]};
		assign trial = {root_s[k], 2'b01};
		assign ge    = rem_n >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (rem_n - trial) : rem_n;
				root_s[k+1] <= {root_s[k][SQ-2:0], ge};
				x_s[k+1]    <= x_s[k] << 2;
				pl_s[k+1]   <= pl_s[k];
			end
		end
	end

	assign out_valid = v_s[SQ];
	assign root      = root_s[SQ];
	assign pl_out    = pl_s[SQ];

endmodule

>>> rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrs_div #(
	parameter int NW  = 33,
	parameter int DNW = 17,
	parameter int PW  = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [NW-1:0]  num,
	input  logic [DNW-1:0] den,
	input  logic [PW-1:0]  pl_in,
	output logic           out_valid,
	output logic [NW-1:0]  quot,
	output logic [PW-1:0]  pl_out
);
	logic           v_s  [NW+1];
	logic [DNW-1:0] r_s  [NW+1];
	logic [NW-1:0]  n_s  [NW+1];
	logic [DNW-1:0] d_s  [NW+1];
	logic [PW-1:0]  pl_s [NW+1];

	assign v_s[0]  = in_valid;
	assign r_s[0]  = '0;
	assign n_s[0]  = num;
	assign d_s[0]  = den;
	assign pl_s[0] = pl_in;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DNW:0] t, dx;
		logic         ge;

		assign t  = {r_s[k], n_s[k][NW-1]};
		assign dx = {1'b0, d_s[k]};
		assign ge = t >= dx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]  <= ge ? DNW'(t - dx) : t[DNW-1:0];
				n_s[k+1]  <= {n_s[k][NW-2:0], ge};
				d_s[k+1]  <= d_s[k];
				pl_s[k+1] <= pl_s[k];
			end
		end
	end

	assign out_valid = v_s[NW];
	assign quot      = n_s[NW];
	assign pl_out    = pl_s[NW];

endmodule

>>> rtl/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// real roots of a*x^2 + b*x + c in signed fixed point
// ----------------------------------------------------------------------------
// coefficients a, b, c enter on the s_axis stream; each transaction gives one
// result transaction on m_axis with both roots in tdata and the status in
// tuser (two roots, linear single root, no real roots, degenerate).
// roots carry FRAC_BITS fraction bits and are truncated toward zero.
// the pipeline has two front-end stages, one square root stage per result bit,
// one setup stage, one divider stage per quotient bit and one output stage.
// throughput is one transaction per cycle unless the receiver stalls; the
// square root and divider are fully unrolled pipelines, so each stage holds
// its own item.
// reset clears all valid bits; no result is pending afterwards.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// coef_a, coef_b, coef_c from bit 0 up, zero padded
	input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// root_plus, root_minus from bit 0 up, zero padded
	output logic [((2*(COEF_WIDTH+FRAC_BITS+3)+7)/8)*8-1:0] m_axis_tdata,
	// status
	output logic [1:0] m_axis_tuser
);
	import qrs_pkg::*;

	localparam int W      = COEF_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int DW     = 2 * W + 2;
	localparam int SQ     = W + 2 + F;
	localparam int NW     = W + F + 1;
	localparam int DNW    = W + 1;
	localparam int PW     = 3 * W + 2;
	localparam int ROOT_W = W + F + 3;
	localparam int OUT_DW = ((2 * ROOT_W + 7) / 8) * 8;

	logic en;

	logic                  dc_valid;
	logic [DW-1:0]         dc_d;
	logic [PW-1:0]         dc_pl;

	logic                  sq_valid;
	logic [SQ-1:0]         sq_root;
	logic [PW-1:0]         sq_pl;

	logic signed [W-1:0]   sa, sb, sc;
	status_t               sst;
	logic signed [NW:0]    bext, cext, sx, base, np, nm, nl, nump;
	logic signed [W:0]     aext, bden, den_s;
	logic                  den_neg;

	logic                  v_s3;
	logic [NW-1:0]         nump_s3, numm_s3;
	logic [DNW-1:0]        den_s3;
	logic                  negp_s3, negm_s3;
	status_t               st_s3;

	logic                  dp_valid, dm_valid;
	logic [NW-1:0]         qp, qm;
	logic [2:0]            dp_pl;
	logic [0:0]            dm_pl;
	status_t               fst;
	logic [ROOT_W-1:0]     rp, rm;

	logic                  out_valid_q;
	logic [ROOT_W-1:0]     rp_q, rm_q;
	status_t               st_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	qrs_disc #(.W(W)) u_disc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.a         (s_axis_tdata[W-1:0]),
		.b         (s_axis_tdata[2*W-1:W]),
		.c         (s_axis_tdata[3*W-1:2*W]),
		.out_valid (dc_valid),
		.d         (dc_d),
		.pl_out    (dc_pl)
	);

	qrs_sqrt #(.DW(DW), .SQ(SQ), .FB(F), .PW(PW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dc_valid),
		.d         (dc_d),
		.pl_in     (dc_pl),
		.out_valid (sq_valid),
		.root      (sq_root),
		.pl_out    (sq_pl)
	);

	// numerator and divisor setup, signs split off
	assign sa   = sq_pl[3*W+1:2*W+2];
	assign sb   = sq_pl[2*W+1:W+2];
	assign sc   = sq_pl[W+1:2];
	assign sst  = status_t'(sq_pl[1:0]);
	assign bext = (NW+1)'(sb);
	assign cext = (NW+1)'(sc);
	assign aext = (W+1)'(sa);
	assign sx   = $signed({1'b0, sq_root[NW-1:0]});
	assign base = -(bext <<< F);
	assign np   = base + sx;
	assign nm   = base - sx;
	assign nl   = -(cext <<< F);
	assign bden = (W+1)'(sb);

	always_comb begin
		if (sst == ST_LINEAR) begin
			nump  = nl;
			den_s = bden;
		end else begin
			nump  = np;
			den_s = aext <<< 1;
		end
		den_neg = den_s < 0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nump_s3 <= (nump < 0) ? NW'(-nump) : NW'(nump);
			numm_s3 <= (nm < 0) ? NW'(-nm) : NW'(nm);
			den_s3  <= (den_s < 0) ? DNW'(-den_s) : DNW'(den_s);
			negp_s3 <= (nump < 0) ^ den_neg;
			negm_s3 <= (nm < 0) ^ den_neg;
			st_s3   <= sst;
		end
	end

	qrs_div #(.NW(NW), .DNW(DNW), .PW(3)) u_div_plus (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (nump_s3),
		.den       (den_s3),
		.pl_in     ({negp_s3, st_s3}),
		.out_valid (dp_valid),
		.quot      (qp),
		.pl_out    (dp_pl)
	);

	qrs_div #(.NW(NW), .DNW(DNW), .PW(1)) u_div_minus (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (numm_s3),
		.den       (den_s3),
		.pl_in     (negm_s3),
		.out_valid (dm_valid),
		.quot      (qm),
		.pl_out    (dm_pl)
	);

	assign fst = status_t'(dp_pl[1:0]);

	always_comb begin
		rp = dp_pl[2] ? -ROOT_W'(qp) : ROOT_W'(qp);
		rm = dm_pl[0] ? -ROOT_W'(qm) : ROOT_W'(qm);
		unique case (fst)
			ST_TWO:    ;
			ST_LINEAR: rm = rp;
			default: begin
				rp = '0;
				rm = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rp_q <= rp;
			rm_q <= rm;
			st_q <= fst;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DW'({rm_q, rp_q});
	assign m_axis_tuser  = st_q;

	// both dividers must stay in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		dp_valid == dm_valid)
		else $error("divider valid bits diverged");

	a_linear_same: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_LINEAR) |->
		m_axis_tdata[ROOT_W-1:0] == m_axis_tdata[2*ROOT_W-1:ROOT_W])
		else $error("linear case roots differ");

	a_no_root_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((m_axis_tuser == ST_NONE) || (m_axis_tuser == ST_DEGEN)) |->
		m_axis_tdata == '0)
		else $error("roots not cleared without real roots");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(qp) && $stable(dp_valid))
		else $error("pipeline moved during stall");

endmodule

>>> sim/quadratic_root_solver_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_top_test
// self-checking bench for the quadratic root solver
// ----------------------------------------------------------------------------
// coefficient triples are queued by an initial block and driven on s_axis with
// random gaps; results on m_axis are checked against a behavioral root
// computation, field by field, in order. one long receiver hold-off fills the
// pipeline so the input stalls.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top_test;
	import qrs_pkg::*;

	localparam int CW = 16;
	localparam int FB = 16;
	localparam int RW = CW + FB + 3;
	localparam int SW = ((3*CW+7)/8)*8;
	localparam int MW = ((2*RW+7)/8)*8;
	localparam int LATENCY = 2*CW + 2*FB + 7;
	localparam int N_RANDOM = 1250;

	typedef struct packed {
		logic signed [RW-1:0] rp;
		logic signed [RW-1:0] rm;
		status_t st;
	} roots_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [SW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [MW-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	logic [3*CW-1:0] coef_queue[$];
	roots_t roots_queue[$];
	int errors = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_cnt = 0;
	int rx_count = 0;
	// handshakes seen at the last rising edge
	bit tx_acc = 1'b0;
	bit rx_acc = 1'b0;

	quadratic_root_solver_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint trunc_div(longint num, longint den);
		longint q;
		q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic longint scaled_sqrt(longint d);
		longint lo, hi, mid, v;
		// floor(sqrt(d*2^32)) by bisection over 128-bit products
		logic [127:0] target, sq;
		target = 128'(d) << (2*FB);
		lo = 0;
		hi = 64'd1 << 34;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			sq = 128'(mid) * 128'(mid);
			if (sq <= target) lo = mid;
			else hi = mid - 1;
		end
		v = lo;
		return v;
	endfunction

	function automatic roots_t solve_roots(logic [3*CW-1:0] abc);
		longint a, b, c, d, s, base, rp, rm;
		roots_t r;
		a = longint'($signed(abc[CW-1:0]));
		b = longint'($signed(abc[2*CW-1:CW]));
		c = longint'($signed(abc[3*CW-1:2*CW]));
		rp = 0;
		rm = 0;
		if (a == 0) begin
			if (b == 0) begin
				r.st = ST_DEGEN;
			end else begin
				rp = trunc_div(-c * (64'sd1 << FB), b);
				rm = rp;
				r.st = ST_LINEAR;
			end
		end else begin
			d = b*b - 4*a*c;
			if (d < 0) begin
				r.st = ST_NONE;
			end else begin
				s = scaled_sqrt(d);
				base = -b * (64'sd1 << FB);
				rp = trunc_div(base + s, 2*a);
				rm = trunc_div(base - s, 2*a);
				r.st = ST_TWO;
			end
		end
		r.rp = rp[RW-1:0];
		r.rm = rm[RW-1:0];
		return r;
	endfunction

	function automatic logic [CW-1:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return '0;
			3, 4: return CW'($signed($urandom_range(0, 20)) - 10);
			default: return CW'($urandom);
		endcase
	endfunction

	task automatic add_item(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c);
		coef_queue.push_back({c, b, a});
	endtask

	always @(posedge clk) begin
		tx_acc <= arst_n && s_axis_tvalid && s_axis_tready;
		rx_acc <= arst_n && m_axis_tvalid && m_axis_tready;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (tx_acc) begin
				tx_gap = $urandom_range(0, 19);
				if ($urandom_range(0, 3) == 0) tx_gap = 0;
			end
			if (tx_acc || !s_axis_tvalid) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (coef_queue.size() > 0) begin
					s_axis_tdata <= SW'(coef_queue[0]);
					roots_queue.push_back(solve_roots(coef_queue[0]));
					void'(coef_queue.pop_front());
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver readiness, with one long hold-off once traffic is flowing
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= (hold_cnt == 0);
			end else if (rx_count == 40 && rx_acc) begin
				hold_cnt = 400;
				m_axis_tready <= 1'b0;
			end else if (rx_acc) begin
				rx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
				m_axis_tready <= (rx_gap == 0);
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= (rx_gap == 0);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		roots_t exp_r;
		logic signed [RW-1:0] got_p, got_m;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			rx_count++;
			got_p = m_axis_tdata[RW-1:0];
			got_m = m_axis_tdata[2*RW-1:RW];
			if (roots_queue.size() == 0) begin
				$display("%0t unexpected result rp=%0d rm=%0d st=%0d", $time, got_p, got_m,
					m_axis_tuser);
				errors++;
			end else begin
				exp_r = roots_queue.pop_front();
				if (got_p !== exp_r.rp) begin
					$display("%0t root_plus expected %0d actual %0d", $time, exp_r.rp, got_p);
					errors++;
				end
				if (got_m !== exp_r.rm) begin
					$display("%0t root_minus expected %0d actual %0d", $time, exp_r.rm, got_m);
					errors++;
				end
				if (m_axis_tuser !== exp_r.st) begin
					$display("%0t status expected %0d actual %0d", $time, exp_r.st, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		int k;
		// directed: extremes, every status, repeated root
		add_item(16'h0001, 16'hfffe, 16'h0001);
		add_item(16'h0001, 16'h0000, 16'hffff);
		add_item(16'h0001, 16'h0000, 16'h0001);
		add_item(16'h0000, 16'h0002, 16'h0003);
		add_item(16'h0000, 16'h8000, 16'h7fff);
		add_item(16'h0000, 16'h0000, 16'h0005);
		add_item(16'h0000, 16'h0000, 16'h0000);
		add_item(16'h8000, 16'h8000, 16'h7fff);
		add_item(16'h7fff, 16'h7fff, 16'h8000);
		add_item(16'h8000, 16'h7fff, 16'h7fff);
		add_item(16'h7fff, 16'h8000, 16'h8000);
		add_item(16'h0001, 16'h8000, 16'h8000);
		add_item(16'hffff, 16'h7fff, 16'h7fff);
		add_item(16'h7fff, 16'h0000, 16'h7fff);
		add_item(16'hffff, 16'hffff, 16'hffff);
		add_item(16'h0000, 16'hffff, 16'h8000);
		add_item(16'h0002, 16'h0004, 16'h0002);
		add_item(16'hffff, 16'h0000, 16'h0000);
		for (k = 0; k < N_RANDOM; k++) begin
			add_item(pick_coef(), pick_coef(), pick_coef());
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (coef_queue.size() == 0 && !s_axis_tvalid);
		wait (roots_queue.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && roots_queue.size() == 0) begin
			$display("quadratic_root_solver_top_test: PASS");
		end else begin
			$display("quadratic_root_solver_top_test: FAIL");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("quadratic_root_solver_top_test: FAIL");
		$finish;
	end

endmodule
